FILE: design/gipt_pkg.sv
// shared types, codes and log table builder for the grey image point transform
`default_nettype none

package gipt_pkg;

    // widest table entry: ln(256) < 8, so three integer bits over the widest fraction
    localparam int LN_MAX_FRAC = 32;
    localparam int LN_MAX_W    = LN_MAX_FRAC + 3;
    localparam int SER_Q       = 60;
    localparam int SER_TERMS   = 40;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_DRAIN     = 1'b1;
    localparam logic MODE_LOG     = 1'b0;
    localparam logic MODE_STRETCH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel_in;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       last_out;
        logic       overflow;
    } out_item_t;

    typedef logic [LN_MAX_W-1:0] ln_rom_t [256];

    // (a*b) >> 60, elaboration only
    function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[SER_Q+63:SER_Q];
    endfunction

    // 2*atanh(a/b) in q60 by series, a/b at most one third
    function automatic logic [63:0] two_atanh(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] z;
        logic [63:0] rem;
        logic [63:0] t;
        logic [63:0] z2;
        logic [63:0] sum;
        z   = '0;
        rem = a;
        sum = '0;
        for (int i = 0; i < SER_Q; i++)
        begin
            rem = rem << 1;
            z   = z << 1;
            if (rem >= b)
            begin
                rem  = rem - b;
                z[0] = 1'b1;
            end
        end
        z2 = mul_q(z, z);
        t  = z;
        for (int i = 0; i < SER_TERMS; i++)
        begin
            sum = sum + t / 64'(2 * i + 1);
            t   = mul_q(t, z2);
        end
        return sum << 1;
    endfunction

    // round(ln(1+p) * 2^frac_bits), built once at elaboration
    function automatic ln_rom_t build_ln_rom(input int frac_bits);
        ln_rom_t     rom;
        logic [63:0] ln2;
        logic [63:0] x;
        logic [63:0] pw;
        logic [63:0] v;
        logic [63:0] k;
        ln2 = two_atanh(64'd1, 64'd3);
        for (int p = 0; p < 256; p++)
        begin
            x  = 64'(p) + 64'd1;
            pw = 64'd1;
            k  = '0;
            for (int j = 0; j < 8; j++)
            begin
                if ((pw << 1) <= x)
                begin
                    pw = pw << 1;
                    k  = k + 64'd1;
                end
            end
            v = k * ln2 + two_atanh(x - pw, x + pw);
            v = (v + (64'd1 << (SER_Q - 1 - frac_bits))) >> (SER_Q - frac_bits);
            rom[p] = v[LN_MAX_W-1:0];
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

FILE: design/gray_image_point_transform.sv
// top level: pixel store, running extremes and shared divide sequencer for point transforms
`default_nettype none

//  channel   dir  handshake                    payload
//  item      in   item_valid / item_ready      op, pixel_in, last_in
//  result    out  result_valid / result_ready  pixel_out, last_out, overflow
//  apb       in   psel, penable, pwrite, pready  register 0 = transform_mode
//
//  a load request does not hold the channel: item_ready stays high
//  a served drain request holds item_ready low through the ram read, log table
//  lookup, operand prep, 8 steps of the shared restoring divider and the output
//  cycle, which loads the result register and raises result_valid
//  a drain that finds nothing to return is taken without leaving idle and gives no result
//  a stalled result holds the next served drain in its output cycle, and every
//  request waits behind it until the result register frees
//  reset clears count, pointer, extremes and flags; the pixel ram is not cleared

module gray_image_point_transform #(
    parameter int MAX_PIXELS   = 65536,
    parameter int LN_FRAC_BITS = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire gipt_pkg::in_item_t   item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output gipt_pkg::out_item_t       result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    import gipt_pkg::*;

    localparam int ADDR_W    = $clog2(MAX_PIXELS);
    localparam int CNT_W     = $clog2(MAX_PIXELS + 1);
    localparam int LN_W      = LN_FRAC_BITS + 3;
    localparam int NUM_W     = LN_W + 8;
    localparam int DIV_STEPS = 8;
    localparam logic REG_TRANSFORM_MODE = 1'b0;

    // log table, worked out at elaboration
    localparam ln_rom_t LN_ROM = build_ln_rom(LN_FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_PREP   = 5'b00100,
        S_DIV    = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic               mode_reg, mode_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rp_reg, rp_next;
    logic [7:0]         max_reg, max_next;
    logic [7:0]         min_reg, min_next;
    logic               done_reg, done_next;
    logic               ovf_reg, ovf_next;
    logic               last_reg, last_next;
    logic [7:0]         pix_reg, pix_next;
    logic [LN_W-1:0]    lp_reg, lp_next;
    logic [LN_W-1:0]    lmax_reg, lmax_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   dsh_reg, dsh_next;
    logic [7:0]         q_reg, q_next;
    logic [2:0]         step_reg, step_next;
    logic               zero_reg, zero_next;
    logic               res_valid_reg, res_valid_next;
    out_item_t          res_reg, res_next;

    logic               accept;
    logic               serve;
    logic [CNT_W-1:0]   load_cnt;
    logic [7:0]         load_max;
    logic [7:0]         load_min;
    logic               load_ovf;
    logic               store_full;
    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_rdata;
    logic [7:0]         diff;
    logic [7:0]         span;
    logic [15:0]        stretch_num;
    logic               cfg_write;

    // ---------------------------------------------------------------
    // handshakes and configuration port
    // ---------------------------------------------------------------
    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign prdata       = (paddr[2] == REG_TRANSFORM_MODE) ? {31'd0, mode_reg} : 32'd0;

    // ---------------------------------------------------------------
    // a load after a finished image starts over from the reset values
    // ---------------------------------------------------------------
    assign load_cnt   = done_reg ? '0 : cnt_reg;
    assign load_max   = done_reg ? 8'd0 : max_reg;
    assign load_min   = done_reg ? 8'hff : min_reg;
    assign load_ovf   = done_reg ? 1'b0 : ovf_reg;
    assign store_full = (load_cnt == CNT_W'(MAX_PIXELS));

    // drain is served only for a complete image with pixels still to return
    assign serve = done_reg && (rp_reg < cnt_reg);

    assign ram_we = accept && (item.op == OP_LOAD) && !store_full;
    assign ram_re = accept && (item.op == OP_DRAIN) && serve;

    gipt_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_cnt[ADDR_W-1:0]),
        .wdata (item.pixel_in),
        .re    (ram_re),
        .raddr (rp_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // stretch operands: (p - min) * 255 as a shift and subtract
    assign diff        = pix_reg - min_reg;
    assign span        = max_reg - min_reg;
    assign stretch_num = {diff, 8'h00} - {8'h00, diff};

    // ---------------------------------------------------------------
    // next-state logic: load bookkeeping and the drain sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        rp_next        = rp_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        done_next      = done_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        pix_next       = pix_reg;
        lp_next        = lp_reg;
        lmax_next      = lmax_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        step_next      = step_reg;
        zero_next      = zero_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (cfg_write && (paddr[2] == REG_TRANSFORM_MODE))
        begin
            mode_next = pwdata[0];
        end

        // result taken downstream
        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.op == OP_LOAD))
                begin
                    rp_next   = done_reg ? '0 : rp_reg;
                    cnt_next  = load_cnt;
                    max_next  = load_max;
                    min_next  = load_min;
                    ovf_next  = load_ovf;
                    done_next = 1'b0;
                    if (store_full)
                    begin
                        // dropped pixel, extremes untouched
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = load_cnt + CNT_W'(1);
                        if (item.pixel_in > load_max)
                        begin
                            max_next = item.pixel_in;
                        end
                        if (item.pixel_in < load_min)
                        begin
                            min_next = item.pixel_in;
                        end
                    end
                    if (item.last_in)
                    begin
                        done_next = 1'b1;
                    end
                end
                else if (accept && serve)
                begin
                    rp_next    = rp_reg + CNT_W'(1);
                    last_next  = ((rp_reg + CNT_W'(1)) == cnt_reg);
                    state_next = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                // ram data is valid here
                pix_next   = ram_rdata;
                lp_next    = LN_ROM[ram_rdata][LN_W-1:0];
                lmax_next  = LN_ROM[max_reg][LN_W-1:0];
                state_next = S_PREP;
            end

            S_PREP:
            begin
                if (mode_reg == MODE_LOG)
                begin
                    rem_next  = {lp_reg, 8'h00} - NUM_W'(lp_reg);
                    dsh_next  = NUM_W'(lmax_reg) << (DIV_STEPS - 1);
                    zero_next = (lmax_reg == '0);
                end
                else
                begin
                    rem_next  = NUM_W'(stretch_num);
                    dsh_next  = NUM_W'(span) << (DIV_STEPS - 1);
                    zero_next = (max_reg <= min_reg) || (pix_reg < min_reg);
                end
                q_next     = '0;
                step_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // restoring division, quotient known to fit in 8 bits
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[6:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[6:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'(DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // wait for the result register to be free
                if (!res_valid_reg || result_ready)
                begin
                    res_next.pixel_out = zero_reg ? 8'd0 : q_reg;
                    res_next.last_out  = last_reg;
                    res_next.overflow  = ovf_reg;
                    res_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_STRETCH;
            cnt_reg       <= '0;
            rp_reg        <= '0;
            max_reg       <= 8'd0;
            min_reg       <= 8'hff;
            done_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            rp_reg        <= rp_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            done_reg      <= done_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
            step_reg      <= step_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        pix_reg  <= pix_next;
        lp_reg   <= lp_next;
        lmax_reg <= lmax_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_rp_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= cnt_reg)
        else $error("read pointer beyond pixel count");

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PIXELS))
        else $error("pixel count beyond store capacity");

    a_drain_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.op == OP_DRAIN) && serve) |=> (state_reg == S_LOOKUP))
        else $error("served drain did not start the sequencer");

    a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && (step_reg == 3'(DIV_STEPS - 1))) |=> (state_reg == S_OUT))
        else $error("divider did not finish after its last step");

endmodule

`default_nettype wire

FILE: design/gipt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module gipt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: bench/gray_image_point_transform_tb.sv
// self-checking bench for the grey image point transform: predicting scoreboard, directed and random requests
`timescale 1ns / 100ps

module gray_image_point_transform_tb;
    import gipt_pkg::*;

    localparam int STORE_DEPTH = 65536;
    localparam int LN_FRAC     = 20;
    // register indexes on the config port
    localparam int REG_MODE    = 0;
    localparam int REG_SPARE   = 1;   // unmapped, a write must change nothing
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 300;

    // predicts every transformed pixel and keeps the expected results in order
    class transform_scoreboard;
        logic [7:0]  store [STORE_DEPTH];
        longint      ln_fix [256];
        int unsigned pixel_total;
        int unsigned drain_ptr;
        int          hi_pix;
        int          lo_pix;
        bit          complete;
        bit          overflowed;
        logic        mode;
        out_item_t   expected_q [$];
        int          errors;
        int          checked;
        int          accepted;
        int          productive;
        int          images;

        function new();
            ln_rom_t rom;
            // ln(1+p) in fixed point, rounded half up
            rom = build_ln_rom(LN_FRAC);
            for (int p = 0; p < 256; p++)
            begin
                ln_fix[p] = longint'(rom[p]);
            end
            clear_image();
            mode = MODE_STRETCH;
        endfunction

        function void clear_image();
            pixel_total = 0;
            drain_ptr   = 0;
            hi_pix      = 0;
            lo_pix      = 255;
            complete    = 1'b0;
            overflowed  = 1'b0;
        endfunction

        function int map_pixel(int p);
            longint den;
            longint r;
            if (mode == MODE_LOG)
            begin
                den = ln_fix[hi_pix];
                if (den == 0)
                    return 0;
                r = (255 * ln_fix[p]) / den;
            end
            else
            begin
                if (hi_pix <= lo_pix || p < lo_pix)
                    return 0;
                r = ((p - lo_pix) * 255) / (hi_pix - lo_pix);
            end
            return (r > 255) ? 255 : int'(r);
        endfunction

        function void set_register(int idx, logic [31:0] value);
            if (idx == REG_MODE)
                mode = value[0];
        endfunction

        function void note_request(in_item_t req);
            out_item_t e;
            accepted++;
            if (req.op == OP_LOAD)
            begin
                productive++;
                if (complete)
                    clear_image();
                if (pixel_total >= STORE_DEPTH)
                    overflowed = 1'b1;
                else
                begin
                    store[pixel_total] = req.pixel_in;
                    pixel_total++;
                    if (req.pixel_in > hi_pix)
                        hi_pix = req.pixel_in;
                    if (req.pixel_in < lo_pix)
                        lo_pix = req.pixel_in;
                end
                if (req.last_in)
                begin
                    complete = 1'b1;
                    images++;
                end
            end
            else if (complete && drain_ptr < pixel_total)
            begin
                productive++;
                e.pixel_out = 8'(map_pixel(store[drain_ptr]));
                e.last_out  = (drain_ptr + 1 == pixel_total);
                e.overflow  = overflowed;
                expected_q.push_back(e);
                drain_ptr++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing pending: pixel_out %0d last_out %0d overflow %0d",
                       got.pixel_out, got.last_out, got.overflow);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.pixel_out !== e.pixel_out)
            begin
                $error("pixel_out expected %0d, got %0d", e.pixel_out, got.pixel_out);
                errors++;
            end
            if (got.last_out !== e.last_out)
            begin
                $error("last_out expected %0d, got %0d", e.last_out, got.last_out);
                errors++;
            end
            if (got.overflow !== e.overflow)
            begin
                $error("overflow expected %0d, got %0d", e.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    in_item_t    item;
    logic        result_valid;
    logic        result_ready;
    out_item_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // idling odds in percent, changed per phase by the main sequence
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    // asks the receiver process for one long hold-off
    bit hold_req       = 1'b0;

    transform_scoreboard sb;

    gray_image_point_transform #(
        .MAX_PIXELS   (STORE_DEPTH),
        .LN_FRAC_BITS (LN_FRAC)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random stalls, plus one long hold-off on request so that
    // the result register fills and the block stops taking drain requests
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // both handshakes sampled with their pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_request(item);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // offers one request and returns at the edge that accepts it; valid is
    // left high, and the next call asserts it again or drops it for a gap
    task automatic send_request(input logic kind, input logic [7:0] pix, input logic last);
        in_item_t req;
        req.op       = kind;
        req.pixel_in = pix;
        req.last_in  = last;
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        // ready is settled by the falling edge, acceptance is at the next rise
        @(negedge clk);
        while (!item_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic load_pixel(input logic [7:0] pix, input logic last);
        send_request(OP_LOAD, pix, last);
    endtask

    // payload of a drain is don't-care, so it is randomised
    task automatic drain_pixel();
        send_request(OP_DRAIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // stop offering and wait until every predicted result is back, then let
    // any trailing drain that gave nothing work its way out
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read_check(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== 32'(sb.mode))
        begin
            $error("transform_mode expected %0d, got %0d", sb.mode, prdata);
            sb.errors++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // pixel value shapes: full range, narrow band, flat, extremes, near black
    function automatic logic [7:0] pick_pixel(int style, int base);
        int v;
        case (style)
            0: v = $urandom_range(255);
            1: v = base + $urandom_range(6) - 3;
            2: v = base;
            3: v = $urandom_range(1) ? ($urandom_range(1) ? 255 : 0) : $urandom_range(255);
            default: v = $urandom_range(3);
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // one well-formed image; a full drain may run one or two past the end,
    // a partial one abandons the rest to the next image's first load
    task automatic send_image(input int size, input int style, input bit full_drain);
        int base;
        int drains;
        base = $urandom_range(255);
        for (int i = 0; i < size; i++)
        begin
            load_pixel(pick_pixel(style, base), i == size - 1);
            if ($urandom_range(99) < 4)
                drain_pixel();
        end
        if (full_drain)
            drains = size + ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0);
        else
            drains = $urandom_range(size - 1);
        for (int i = 0; i < drains; i++)
            drain_pixel();
    endtask

    // mostly well-formed images with random content, some stray requests
    task automatic run_mix(input int target);
        int goal;
        int size;
        goal = sb.productive + target;
        while (sb.productive < goal)
        begin
            if ($urandom_range(99) < 85)
            begin
                size = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                send_image(size, $urandom_range(4), $urandom_range(9) != 0);
            end
            else
                send_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: mode left at its reset value (stretch) to start with
        reg_read_check(REG_MODE);
        drain_pixel();                  // nothing loaded yet
        load_pixel(8'd0, 1'b0);
        drain_pixel();                  // image not complete
        load_pixel(8'd255, 1'b1);
        drain_pixel();
        drain_pixel();
        drain_pixel();                  // all pixels already returned
        load_pixel(8'd9, 1'b0);         // new image after completion
        load_pixel(8'd9, 1'b1);
        drain_pixel();                  // flat image, stretch divisor zero
        drain_pixel();
        settle();
        reg_write(REG_MODE, 32'(MODE_LOG));
        reg_write(REG_SPARE, 32'(MODE_STRETCH));   // unmapped, ignored
        reg_read_check(REG_MODE);
        load_pixel(8'd0, 1'b1);
        drain_pixel();                  // max of zero, log divisor zero
        load_pixel(8'd255, 1'b0);
        load_pixel(8'd1, 1'b0);
        load_pixel(8'd128, 1'b1);
        drain_pixel();
        drain_pixel();
        drain_pixel();
        load_pixel(8'd5, 1'b0);
        load_pixel(8'd200, 1'b1);
        drain_pixel();
        load_pixel(8'd50, 1'b1);        // abandons the half-drained image
        drain_pixel();
        drain_pixel();
        settle();

        // random, sender rarely idle and receiver mostly stalled
        reg_write(REG_MODE, 32'(MODE_STRETCH));
        send_gap_pct   = 10;
        recv_stall_pct = 84;
        run_mix(500);
        settle();

        // random, the other way round
        reg_write(REG_MODE, 32'(MODE_LOG));
        reg_read_check(REG_MODE);
        send_gap_pct   = 84;
        recv_stall_pct = 10;
        run_mix(500);
        settle();

        // random at full rate, with a long receiver hold-off in between
        reg_write(REG_MODE, 32'(MODE_STRETCH));
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_mix(250);
        hold_req = 1'b1;
        send_image(48, 0, 1'b1);
        settle();
        reg_write(REG_MODE, 32'(MODE_LOG));
        run_mix(250);
        settle();

        if (sb.expected_q.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            sb.errors += sb.expected_q.size();
        end
        $display("covered %0d requests over %0d images in both modes, %0d results checked",
                 sb.accepted, sb.images, sb.checked);
        $display("including empty and early drains, flat and black images, a long result stall");
        if (sb.errors == 0)
            $display("gray_image_point_transform: match");
        else
            $display("gray_image_point_transform: mismatch");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #8000000;
        $display("gray_image_point_transform: mismatch");
        $finish;
    end

endmodule

FILE: files.f
design/gipt_pkg.sv
design/gipt_ram.sv
design/gray_image_point_transform.sv
bench/gray_image_point_transform_tb.sv
